>>> rtl/keyframe_interpolator_core_defines.svh
// Assertion macros shared by the interpolator modules.
`ifndef KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define KEYFRAME_INTERPOLATOR_CORE_DEFINES_SVH
`define KI_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`define KI_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/kfi_pkg.sv
package kfi_pkg;
  typedef enum logic [2:0] {
    OP_LINEAR  = 3'd0,
    OP_EASEIN  = 3'd1,
    OP_EASEOUT = 3'd2,
    OP_INOUT   = 3'd3,
    OP_BEZIER  = 3'd4,
    OP_HOLD    = 3'd5,
    OP_RSVD6   = 3'd6,
    OP_RSVD7   = 3'd7
  } kfi_op_t;

  typedef enum logic [1:0] {
    CLS_START  = 2'd0,
    CLS_END    = 2'd1,
    CLS_BLEND  = 2'd2
  } kfi_cls_t;

  typedef struct packed {
    kfi_cls_t    cls;
    kfi_op_t     op;
    logic [31:0] num;
    logic [31:0] den;
    logic signed [31:0] sv;
    logic signed [31:0] ev;
    logic signed [31:0] ih;
    logic signed [31:0] oh;
  } kfi_job_t;
endpackage

>>> rtl/kfi_front.sv
module kfi_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [31:0]         in_start_time,
  input  logic signed [31:0]  in_start_value,
  input  logic [31:0]         in_end_time,
  input  logic signed [31:0]  in_end_value,
  input  logic [31:0]         in_query_time,
  input  logic [2:0]          in_opcode,
  input  logic signed [31:0]  in_in_handle,
  input  logic signed [31:0]  in_out_handle,
  output logic                job_valid,
  input  logic                job_ready,
  output kfi_pkg::kfi_job_t   job
);
  import kfi_pkg::*;

  logic     vld_r;
  kfi_job_t job_r;
  kfi_job_t job_nxt;

  assign in_ready  = !vld_r || job_ready;
  assign job_valid = vld_r;
  assign job       = job_r;

  always_comb begin
    job_nxt     = '0;
    job_nxt.op  = kfi_op_t'(in_opcode);
    job_nxt.num = in_query_time - in_start_time;
    job_nxt.den = in_end_time - in_start_time;
    job_nxt.sv  = in_start_value;
    job_nxt.ev  = in_end_value;
    job_nxt.ih  = in_in_handle;
    job_nxt.oh  = in_out_handle;
    if (in_query_time <= in_start_time) begin
      job_nxt.cls = CLS_START;
    end else if (in_query_time >= in_end_time) begin
      job_nxt.cls = CLS_END;
    end else begin
      job_nxt.cls = CLS_BLEND;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r <= job_nxt;
    end
  end
endmodule

>>> rtl/kfi_fifo.sv
module kfi_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  kfi_pkg::kfi_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output kfi_pkg::kfi_job_t rd_data
);
  import kfi_pkg::*;

  kfi_job_t   mem_r [2];
  logic       wp_r;
  logic       rp_r;
  logic [1:0] cnt_r;

  assign wr_ready = cnt_r != 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp_r <= !wp_r;
      end
      if (rd_valid && rd_ready) begin
        rp_r <= !rp_r;
      end
      cnt_r <= cnt_r + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem_r[wp_r] <= wr_data;
    end
  end

  `include "keyframe_interpolator_core_defines.svh"
  `KI_ASSERT_IMP(a_fifo_cnt, clk, rst_n, 1'b1, cnt_r <= 2'd2, "queue count out of range")
  `KI_ASSERT_NXT(a_fifo_full, clk, rst_n, cnt_r == 2'd2 && !rd_ready, cnt_r == 2'd2, "full queue lost an entry")
  `KI_ASSERT_IMP(a_fifo_ptr, clk, rst_n, cnt_r == 2'd0 || cnt_r == 2'd2, wp_r == rp_r, "pointers disagree with count")
endmodule

>>> rtl/kfi_back.sv
module kfi_back #(
  parameter int FB = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               job_valid,
  output logic               job_ready,
  input  kfi_pkg::kfi_job_t  job,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_saturated
);
  import kfi_pkg::*;

  localparam int NS   = 34;
  localparam int QW   = 32 + FB;
  localparam int ST   = QW + 8;
  localparam logic [FB:0] ONE = (FB+1)'(1) << FB;

  // Pipeline stages 0..QW-1 perform restoring division one bit per stage.
  logic              v_r   [ST];
  kfi_job_t          j_r   [ST];
  logic [QW-1:0]     q_r   [QW+1];
  logic [32:0]       rm_r  [QW+1];

  logic adv;
  assign adv       = !out_valid || out_ready;
  assign job_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ST; i++) v_r[i] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= job_valid;
      for (int i = 1; i < ST; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      j_r[0]  <= job;
      q_r[0]  <= {job.num, FB'(0)};
      rm_r[0] <= '0;
      for (int i = 1; i < ST; i++) j_r[i] <= j_r[i-1];
      for (int i = 0; i < QW; i++) begin
        logic [33:0] tr;
        tr = {rm_r[i], q_r[i][QW-1]} - {2'b0, j_r[i].den};
        if (!tr[33]) begin
          rm_r[i+1] <= tr[32:0];
          q_r[i+1]  <= {q_r[i][QW-2:0], 1'b1};
        end else begin
          rm_r[i+1] <= {rm_r[i][31:0], q_r[i][QW-1]};
          q_r[i+1]  <= {q_r[i][QW-2:0], 1'b0};
        end
      end
    end
  end

  // Weight and Bezier basis stages.
  logic [FB:0] t1_r, m1_r;
  logic [2*FB+1:0] tt_r, mm_r, i2_r, u2_r;
  logic [FB+1:0] t2_r, m2_r, e2_r;
  logic [FB:0] t3_r, m3_r;
  logic [2*FB+3:0] b0p_r, b1p_r, b2p_r, b3p_r;
  logic [FB+2:0] w_r, w2_r, b0_r, b1_r, b2_r, b3_r;
  logic signed [32:0] p1_r, p2_r;
  logic signed [32:0] d_r;
  logic signed [33+FB+3:0] pa_r, pb_r, pc_r, pd_r, pw_r;
  logic signed [NS+FB+6:0] sum_r;
  logic signed [31:0] res_r;
  logic sat_r;
  logic signed [31:0] res_nxt;
  logic sat_nxt;

  logic [FB:0] tq;
  assign tq = q_r[QW][FB:0];

  always_ff @(posedge clk) begin
    if (adv) begin
      t1_r <= tq;
      m1_r <= ONE - tq;
      tt_r <= (2*FB+2)'(tq) * (2*FB+2)'(tq);
      mm_r <= (2*FB+2)'(ONE - tq) * (2*FB+2)'(ONE - tq);
      u2_r <= (2*FB+2)'((ONE - tq) << 1) * (2*FB+2)'((ONE - tq) << 1);
      t3_r <= t1_r;
      m3_r <= m1_r;
      t2_r <= (FB+2)'(tt_r >> FB);
      m2_r <= (FB+2)'(mm_r >> FB);
      e2_r <= (FB+2)'(tt_r >> (FB-1));
      i2_r <= u2_r;
      b0p_r <= (2*FB+4)'(m2_r) * (2*FB+4)'(m3_r);
      b1p_r <= (2*FB+4)'(m2_r) * (2*FB+4)'(t3_r);
      b2p_r <= (2*FB+4)'(m3_r) * (2*FB+4)'(t2_r);
      b3p_r <= (2*FB+4)'(t2_r) * (2*FB+4)'(t3_r);
      case (j_r[QW+2].op)
        OP_EASEIN:  w_r <= (FB+3)'(t2_r);
        OP_EASEOUT: w_r <= (FB+3)'(ONE) - (FB+3)'(m2_r);
        OP_INOUT: begin
          if (!t3_r[FB-1]) w_r <= (FB+3)'(e2_r);
          else w_r <= (FB+3)'(ONE) - (FB+3)'(i2_r >> (FB+1));
        end
        default:    w_r <= (FB+3)'(t3_r);
      endcase
      w2_r <= w_r;
      b0_r <= (FB+3)'(b0p_r >> FB);
      b1_r <= (FB+3)'(3 * (b1p_r >> FB));
      b2_r <= (FB+3)'(3 * (b2p_r >> FB));
      b3_r <= (FB+3)'(b3p_r >> FB);
      p1_r <= 33'(j_r[QW+3].sv) + 33'(j_r[QW+3].oh);
      p2_r <= 33'(j_r[QW+3].ev) + 33'(j_r[QW+3].ih);
      d_r  <= 33'(j_r[QW+3].ev) - 33'(j_r[QW+3].sv);
      pa_r <= $signed(j_r[QW+4].sv) * $signed({1'b0, b0_r});
      pb_r <= p1_r * $signed({1'b0, b1_r});
      pc_r <= p2_r * $signed({1'b0, b2_r});
      pd_r <= $signed(j_r[QW+4].ev) * $signed({1'b0, b3_r});
      pw_r <= d_r * $signed({1'b0, w2_r});
      if (j_r[QW+5].op == OP_BEZIER) begin
        sum_r <= (NS+FB+7)'(pa_r) + (NS+FB+7)'(pb_r) + (NS+FB+7)'(pc_r) + (NS+FB+7)'(pd_r);
      end else begin
        sum_r <= (NS+FB+7)'(pw_r);
      end
    end
  end

  logic signed [NS+6:0] sh;
  assign sh = (NS+7)'(sum_r >>> FB);

  always_comb begin
    res_nxt = sh[31:0];
    sat_nxt = 1'b0;
    case (j_r[QW+6].cls)
      CLS_START: res_nxt = j_r[QW+6].sv;
      CLS_END:   res_nxt = j_r[QW+6].ev;
      default: begin
        if (j_r[QW+6].op == OP_HOLD) begin
          res_nxt = j_r[QW+6].sv;
        end else if (j_r[QW+6].op == OP_BEZIER) begin
          if (sh > (NS+7)'(32'sh7fffffff)) begin
            res_nxt = 32'sh7fffffff;
            sat_nxt = 1'b1;
          end else if (sh < -(NS+7)'(33'sh080000000)) begin
            res_nxt = 32'sh80000000;
            sat_nxt = 1'b1;
          end else begin
            res_nxt = sh[31:0];
          end
        end else begin
          res_nxt = j_r[QW+6].sv + sh[31:0];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign out_valid        = v_r[ST-1];
  assign out_result_value = res_r;
  assign out_saturated    = sat_r;

  `include "keyframe_interpolator_core_defines.svh"
  `KI_ASSERT_IMP(a_back_sat, clk, rst_n, out_valid && out_saturated, j_r[ST-1].op == OP_BEZIER, "saturation outside Bezier")
  `KI_ASSERT_NXT(a_back_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_result_value), "result changed while stalled")
  `KI_ASSERT_IMP(a_back_rdy, clk, rst_n, !out_valid, job_ready, "back end blocked while empty")
endmodule

>>> rtl/keyframe_interpolator_core.sv
// Channel  | Handshake            | Payload
// in_      | in_valid/in_ready    | times, values, opcode, handles
// out_     | out_valid/out_ready  | result_value, saturated
// One item per cycle is accepted unless a stall on out_ready backs up the queue; a result
// is offered once its input has passed the front register, the queue, the divider of
// 32 + FRACTION_BITS stages and the blend pipeline.
// Reset is synchronous and active low and clears only the valid flags and the queue pointers and count.
// A stall on out_ready freezes the back pipeline; the two-entry queue lets the
// front keep taking items until it fills.
module keyframe_interpolator_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        in_start_time,
  input  logic signed [31:0] in_start_value,
  input  logic [31:0]        in_end_time,
  input  logic signed [31:0] in_end_value,
  input  logic [31:0]        in_query_time,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_in_handle,
  input  logic signed [31:0] in_out_handle,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_result_value,
  output logic               out_saturated
);
  import kfi_pkg::*;

  logic     fv, fr, qv, qr;
  kfi_job_t fj, qj;

  kfi_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_start_time, .in_start_value,
    .in_end_time, .in_end_value, .in_query_time, .in_opcode, .in_in_handle,
    .in_out_handle, .job_valid(fv), .job_ready(fr), .job(fj)
  );

  kfi_fifo u_fifo (
    .clk, .rst_n, .wr_valid(fv), .wr_ready(fr), .wr_data(fj),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qj)
  );

  kfi_back #(.FB(FRACTION_BITS)) u_back (
    .clk, .rst_n, .job_valid(qv), .job_ready(qr), .job(qj),
    .out_valid, .out_ready, .out_result_value, .out_saturated
  );
endmodule
